>>> hw/rtl/tsa_pkg.sv
`default_nettype none
package tsa_pkg;

    localparam int VALUE_BITS = 64;

    // configuration register indexes
    localparam logic [1:0] CFG_VALUE_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_SIGNED_MODE    = 2'd1;
    localparam logic [1:0] CFG_AGGREGATE_KIND = 2'd2;

    // value width codes
    localparam logic [2:0] WIDTH_8    = 3'd0;
    localparam logic [2:0] WIDTH_16   = 3'd1;
    localparam logic [2:0] WIDTH_32   = 3'd2;
    localparam logic [2:0] WIDTH_64   = 3'd3;
    localparam logic [2:0] WIDTH_BOOL = 3'd4;

    // aggregate kinds
    localparam logic [2:0] AGG_AVERAGE    = 3'd0;
    localparam logic [2:0] AGG_SUM        = 3'd1;
    localparam logic [2:0] AGG_MINIMUM    = 3'd2;
    localparam logic [2:0] AGG_MAXIMUM    = 3'd3;
    localparam logic [2:0] AGG_ZERO_COUNT = 3'd4;

    localparam logic [2:0] RESET_VALUE_WIDTH    = WIDTH_64;
    localparam logic       RESET_SIGNED_MODE    = 1'b0;
    localparam logic [2:0] RESET_AGGREGATE_KIND = AGG_SUM;

    localparam logic [VALUE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] MOST_POSITIVE = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] ALL_ONES      = {VALUE_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_RUN = 3'b001,
        S_DIV = 3'b010,
        S_FIN = 3'b100
    } t_state;

    typedef struct packed {
        logic acc;        // item accepted this cycle
        logic close_now;  // last item, result comes straight from the accumulators
        logic div_start;  // last item, average needs the divider
        logic div_step;
        logic div_finish; // load the quotient into the output register
    } t_cmd;

    typedef struct packed {
        logic avg_sel;
        logic div_last;
    } t_stat;

    function automatic logic [VALUE_BITS-1:0] widen(
        input logic [VALUE_BITS-1:0] raw,
        input logic [2:0]            width,
        input logic                  sgn
    );
        logic [VALUE_BITS-1:0] v;
        v = '0;
        case (width) inside
            WIDTH_8, WIDTH_BOOL: v = {{(VALUE_BITS-8){sgn & raw[7]}}, raw[7:0]};
            WIDTH_16:            v = {{(VALUE_BITS-16){sgn & raw[15]}}, raw[15:0]};
            WIDTH_32:            v = {{(VALUE_BITS-32){sgn & raw[31]}}, raw[31:0]};
            WIDTH_64:            v = raw;
            default:             v = '0;
        endcase
        return v;
    endfunction

    function automatic logic less_than(
        input logic [VALUE_BITS-1:0] a,
        input logic [VALUE_BITS-1:0] b,
        input logic                  sgn
    );
        logic [VALUE_BITS-1:0] fa;
        logic [VALUE_BITS-1:0] fb;
        fa = {a[VALUE_BITS-1] ^ sgn, a[VALUE_BITS-2:0]};
        fb = {b[VALUE_BITS-1] ^ sgn, b[VALUE_BITS-2:0]};
        return fa < fb;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tsa_ctrl.sv
`default_nettype none
module tsa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_last,
    input  wire logic          i_out_stall,
    input  wire tsa_pkg::t_stat i_stat,
    output tsa_pkg::t_cmd      o_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid
);

    tsa_pkg::t_state r_state;
    tsa_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_busy;

    assign out_busy    = r_out_valid & i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tsa_pkg::S_RUN: begin
                // a closing item waits only while the previous result is held
                o_in_stall = i_last & out_busy;
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.acc = 1'b1;
                    if (i_last) begin
                        if (i_stat.avg_sel) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = tsa_pkg::S_DIV;
                        end else begin
                            o_cmd.close_now = 1'b1;
                        end
                    end
                end
            end
            tsa_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = tsa_pkg::S_FIN;
                end
            end
            tsa_pkg::S_FIN: begin
                if (!out_busy) begin
                    o_cmd.div_finish = 1'b1;
                    n_state          = tsa_pkg::S_RUN;
                end
            end
            default: n_state = tsa_pkg::S_RUN;
        endcase
    end

    always_comb begin
        if (o_cmd.close_now || o_cmd.div_finish) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = out_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsa_pkg::S_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/tsa_dpath.sv
`default_nettype none
module tsa_dpath #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [2:0]    i_cfg_data,
    input  wire logic [63:0]   i_raw_value,
    input  wire logic          i_present,
    input  wire tsa_pkg::t_cmd i_cmd,
    output tsa_pkg::t_stat     o_stat,
    output logic [63:0]        o_aggregate_result
);

    localparam int VB        = tsa_pkg::VALUE_BITS;
    localparam int STEP_BITS = $clog2(VB);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(VB - 1);

    // configuration
    logic [2:0] r_width;
    logic       r_signed;
    logic       n_signed;
    logic [2:0] r_kind;

    // accumulators
    logic [VB-1:0]         r_sum,  n_sum;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] r_zcnt, n_zcnt;
    logic [VB-1:0]         r_min,  n_min;
    logic [VB-1:0]         r_max,  n_max;

    // divider
    logic [VB-1:0]         r_quo;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_dvs;
    logic                  r_neg;
    logic [STEP_BITS-1:0]  r_step;
    logic [COUNT_BITS:0]   rem_shift;
    logic [COUNT_BITS:0]   rem_diff;
    logic                  rem_ge;

    logic [VB-1:0] wide;
    logic          upd;
    logic          restart;
    logic          sum_neg;
    logic [VB-1:0] sum_mag;
    logic [VB-1:0] direct_res;
    logic [VB-1:0] avg_res;
    logic [VB-1:0] r_result;

    assign wide = tsa_pkg::widen(i_raw_value, r_width, r_signed);
    assign upd  = i_cmd.acc & i_present;

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_zcnt  = r_zcnt;
        n_min   = r_min;
        n_max   = r_max;
        if (upd) begin
            n_sum   = r_sum + wide;
            n_count = r_count + COUNT_BITS'(1);
            if (wide == '0) begin
                n_zcnt = r_zcnt + COUNT_BITS'(1);
            end
            if (!tsa_pkg::less_than(wide, r_max, r_signed)) begin
                n_max = wide;
            end
            if (!tsa_pkg::less_than(r_min, wide, r_signed)) begin
                n_min = wide;
            end
        end
    end

    always_comb begin
        case (r_kind)
            tsa_pkg::AGG_SUM:        direct_res = n_sum;
            tsa_pkg::AGG_MINIMUM:    direct_res = n_min;
            tsa_pkg::AGG_MAXIMUM:    direct_res = n_max;
            tsa_pkg::AGG_ZERO_COUNT: direct_res = VB'(n_zcnt);
            default:                 direct_res = '0;
        endcase
    end

    // a new sign mode starts a fresh run with its own start values
    assign n_signed = (i_cfg_we && i_cfg_index == tsa_pkg::CFG_SIGNED_MODE) ?
                      i_cfg_data[0] : r_signed;
    assign restart  = i_cmd.close_now | i_cmd.div_finish |
                      (i_cfg_we && i_cfg_index == tsa_pkg::CFG_SIGNED_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= tsa_pkg::RESET_VALUE_WIDTH;
            r_signed <= tsa_pkg::RESET_SIGNED_MODE;
            r_kind   <= tsa_pkg::RESET_AGGREGATE_KIND;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsa_pkg::CFG_VALUE_WIDTH:    r_width  <= i_cfg_data;
                tsa_pkg::CFG_SIGNED_MODE:    r_signed <= i_cfg_data[0];
                tsa_pkg::CFG_AGGREGATE_KIND: r_kind   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_sum   <= '0;
            r_count <= '0;
            r_zcnt  <= '0;
            r_min   <= (i_rst_n && n_signed) ? tsa_pkg::MOST_POSITIVE : tsa_pkg::ALL_ONES;
            r_max   <= (i_rst_n && n_signed) ? tsa_pkg::MOST_NEGATIVE : '0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_zcnt  <= n_zcnt;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    // restoring division of the sum magnitude by the count, one bit a step
    assign sum_neg   = r_signed & n_sum[VB-1];
    assign sum_mag   = sum_neg ? (~n_sum + VB'(1)) : n_sum;
    assign rem_shift = {r_rem, r_quo[VB-1]};
    assign rem_diff  = rem_shift - {1'b0, r_dvs};
    assign rem_ge    = !rem_diff[COUNT_BITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo  <= sum_mag;
            r_rem  <= '0;
            r_dvs  <= n_count;
            r_neg  <= sum_neg;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[VB-2:0], rem_ge};
            r_rem  <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
            r_step <= r_step + STEP_BITS'(1);
        end
    end

    always_comb begin
        if (r_dvs == '0) begin
            avg_res = '0;
        end else if (r_neg) begin
            avg_res = ~r_quo + VB'(1);
        end else begin
            avg_res = r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.close_now) begin
            r_result <= direct_res;
        end else if (i_cmd.div_finish) begin
            r_result <= avg_res;
        end
    end

    assign o_stat = '{avg_sel:  (r_kind == tsa_pkg::AGG_AVERAGE),
                      div_last: (r_step == LAST_STEP)};
    assign o_aggregate_result = r_result;

endmodule
`default_nettype wire

>>> hw/rtl/typed_statistics_aggregator.sv
// Statistics aggregator: sum, zero count, min, max and average of a run.
//
// Input channel (i_in_valid / o_in_stall) carries i_raw_value, i_present and
// i_last. A present item is cut to the configured width, extended to 64 bits
// and folded into the accumulators in the cycle it is accepted, so runs stream
// at one item per cycle when not stalled. The item with i_last closes the run.
// Output channel (o_out_valid / i_out_stall) carries o_aggregate_result, one
// result per closed run, from an output register.
// Sum, minimum, maximum and zero count appear in the cycle after the closing
// item is accepted. Average runs a 64-step restoring divider, one quotient bit
// per cycle; its result is loaded once the divider is done and the output
// register is free, and the input stalls until then.
// While a result is held by i_out_stall, ordinary items are still accepted;
// only a closing item waits until the output register is free.
// Reset (i_rst_n low, synchronous) restores the configuration defaults
// (64-bit, unsigned, sum), resets the accumulators and drops any result.
// Configuration writes go through i_cfg_we / i_cfg_index / i_cfg_data; a
// write to the signed mode register restarts the run.
`default_nettype none
module typed_statistics_aggregator #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [2:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_raw_value,
    input  wire logic        i_present,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_aggregate_result
);

    tsa_pkg::t_cmd  cmd;
    tsa_pkg::t_stat stat;

    tsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_last),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    tsa_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_raw_value        (i_raw_value),
        .i_present          (i_present),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_aggregate_result (o_aggregate_result)
    );

endmodule
`default_nettype wire

>>> hw/rtl/tsa_chk.sv
`default_nettype none
module tsa_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_last,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [63:0] o_aggregate_result
);

    // a held result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_aggregate_result))
        else $error("result changed while stalled");

    // never close a run while the previous result is still held
    a_no_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && !o_in_stall && i_last && o_out_valid && i_out_stall))
        else $error("closing item taken while output register busy");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind typed_statistics_aggregator tsa_chk u_tsa_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_last             (i_last),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_aggregate_result (o_aggregate_result)
);
`default_nettype wire
